FILE: rtl/core/hcb_pkg.sv
// hcb_pkg: shared types and constants of the hex command to bus request unit
// no dependencies; used by every module of the block by scoped names
`timescale 1ns / 1ps

package hcb_pkg;

  // digits in one address and in one write data word
  localparam int unsigned HexDigits = 8;
  localparam int unsigned CntW      = 4;
  localparam logic [CntW-1:0] DigitsLast = CntW'(HexDigits);

  localparam int unsigned CharW = 8;
  localparam int unsigned WordW = 32;
  localparam int unsigned NibW  = 4;

  // character codes
  localparam logic [CharW-1:0] ChZero   = 8'h30;  // '0'
  localparam logic [CharW-1:0] ChNine   = 8'h39;  // '9'
  localparam logic [CharW-1:0] ChUpA    = 8'h41;  // 'A'
  localparam logic [CharW-1:0] ChUpF    = 8'h46;  // 'F'
  localparam logic [CharW-1:0] ChUpR    = 8'h52;  // 'R'
  localparam logic [CharW-1:0] ChLowR   = 8'h72;  // 'r'
  localparam logic [CharW-1:0] ChUpW    = 8'h57;  // 'W'
  localparam logic [CharW-1:0] ChLowW   = 8'h77;  // 'w'
  localparam logic [NibW-1:0]  NibTen   = 4'hA;

  // classification of one received character
  typedef struct packed {
    logic            is_hex;
    logic [NibW-1:0] nibble;
    logic            sel_read;
    logic            sel_write;
  } char_class_t;

  // one bus request
  typedef struct packed {
    logic             is_write;
    logic [WordW-1:0] bus_address;
    logic [WordW-1:0] write_data;
  } bus_req_t;

endpackage

FILE: rtl/core/hcb_char_decode.sv
// hcb_char_decode: classifies one ascii character as hex digit or mode letter
// depends on hcb_pkg
`timescale 1ns / 1ps

module hcb_char_decode (
  input  logic [hcb_pkg::CharW-1:0] char_i,
  output hcb_pkg::char_class_t      class_o
);

  logic is_dec;
  logic is_alpha;

  assign is_dec   = (char_i >= hcb_pkg::ChZero) && (char_i <= hcb_pkg::ChNine);
  assign is_alpha = (char_i >= hcb_pkg::ChUpA) && (char_i <= hcb_pkg::ChUpF);

  always_comb begin
    class_o.is_hex    = is_dec || is_alpha;
    class_o.sel_read  = (char_i == hcb_pkg::ChUpR) || (char_i == hcb_pkg::ChLowR);
    class_o.sel_write = (char_i == hcb_pkg::ChUpW) || (char_i == hcb_pkg::ChLowW);
    if (is_alpha) begin
      class_o.nibble = hcb_pkg::NibW'(char_i - hcb_pkg::ChUpA) + hcb_pkg::NibTen;
    end else begin
      class_o.nibble = hcb_pkg::NibW'(char_i - hcb_pkg::ChZero);
    end
  end

endmodule

FILE: rtl/core/hcb_parser.sv
// hcb_parser: mode, digit counters and shift registers; forms bus requests
// depends on hcb_pkg
`timescale 1ns / 1ps

module hcb_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  hcb_pkg::char_class_t class_i,
  output logic                 req_valid_o,
  output hcb_pkg::bus_req_t    req_o
);

  logic                       read_mode_q, read_mode_d;
  logic [hcb_pkg::CntW-1:0]   addr_cnt_q, addr_cnt_d;
  logic [hcb_pkg::CntW-1:0]   data_cnt_q, data_cnt_d;
  logic [hcb_pkg::WordW-1:0]  addr_q, addr_d;
  logic [hcb_pkg::WordW-1:0]  data_q, data_d;
  logic                       addr_phase;
  logic [hcb_pkg::WordW-1:0]  addr_shifted;
  logic [hcb_pkg::WordW-1:0]  data_shifted;
  logic [hcb_pkg::CntW-1:0]   addr_cnt_inc;
  logic [hcb_pkg::CntW-1:0]   data_cnt_inc;

  assign addr_phase   = addr_cnt_q < hcb_pkg::DigitsLast;
  assign addr_shifted = {addr_q[hcb_pkg::WordW-hcb_pkg::NibW-1:0], class_i.nibble};
  assign data_shifted = {data_q[hcb_pkg::WordW-hcb_pkg::NibW-1:0], class_i.nibble};
  assign addr_cnt_inc = addr_cnt_q + 1'b1;
  assign data_cnt_inc = data_cnt_q + 1'b1;

  always_comb begin
    read_mode_d = read_mode_q;
    addr_cnt_d  = addr_cnt_q;
    data_cnt_d  = data_cnt_q;
    addr_d      = addr_q;
    data_d      = data_q;
    req_valid_o = 1'b0;
    req_o       = '0;
    if (addr_phase) begin
      if (class_i.sel_read) begin
        read_mode_d = 1'b1;
      end else if (class_i.sel_write) begin
        read_mode_d = 1'b0;
      end
      if (class_i.is_hex) begin
        addr_d     = addr_shifted;
        addr_cnt_d = addr_cnt_inc;
        // read request goes out as soon as the address is complete
        if ((addr_cnt_inc == hcb_pkg::DigitsLast) && read_mode_d) begin
          req_valid_o       = 1'b1;
          req_o.bus_address = addr_shifted;
          addr_d            = '0;
          addr_cnt_d        = '0;
          data_d            = '0;
          data_cnt_d        = '0;
        end
      end
    end else if (class_i.is_hex) begin
      data_d     = data_shifted;
      data_cnt_d = data_cnt_inc;
      if (data_cnt_inc == hcb_pkg::DigitsLast) begin
        req_valid_o       = 1'b1;
        req_o.is_write    = 1'b1;
        req_o.bus_address = addr_q;
        req_o.write_data  = data_shifted;
        addr_d            = '0;
        addr_cnt_d        = '0;
        data_d            = '0;
        data_cnt_d        = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_mode_q <= 1'b1;
      addr_cnt_q  <= '0;
      data_cnt_q  <= '0;
      addr_q      <= '0;
      data_q      <= '0;
    end else if (step_i) begin
      read_mode_q <= read_mode_d;
      addr_cnt_q  <= addr_cnt_d;
      data_cnt_q  <= data_cnt_d;
      addr_q      <= addr_d;
      data_q      <= data_d;
    end
  end

endmodule

FILE: rtl/core/hcb_out_reg.sv
// hcb_out_reg: result register holding one bus request until it is taken
// depends on hcb_pkg
`timescale 1ns / 1ps

module hcb_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  hcb_pkg::bus_req_t req_i,
  output logic              free_o,
  output logic              valid_o,
  input  logic              ready_i,
  output hcb_pkg::bus_req_t req_o
);

  logic              valid_q;
  hcb_pkg::bus_req_t req_q;

  // free when empty or when the held request is taken in this cycle
  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign req_o   = req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      req_q <= req_i;
    end
  end

endmodule

FILE: rtl/core/hex_command_to_bus_request_unit.sv
// hex_command_to_bus_request_unit: top level, character stream in, bus requests out
// depends on hcb_pkg, hcb_char_decode, hcb_parser, hcb_out_reg
`timescale 1ns / 1ps

//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+------------------------------------
//  in       | input     | in_valid_i / in_ready_o | char_in_i[7:0]
//  out      | output    | out_valid_o / out_ready_i | is_write_o, bus_address_o, write_data_o
//
// one character per cycle while the result register is free: a character is captured in the
// input register, then decoded and applied to the parser state once the result register is free,
// and any request lands in the result register on that same step
// reset (async, active low) returns to read mode with empty counters and shift registers
// the input register holds only while the result register is full and not taken;
// in_ready_o drops only in that case

module hex_command_to_bus_request_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [hcb_pkg::CharW-1:0]   char_in_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        is_write_o,
  output logic [hcb_pkg::WordW-1:0]   bus_address_o,
  output logic [hcb_pkg::WordW-1:0]   write_data_o
);

  // input register
  logic                       in_valid_q;
  logic [hcb_pkg::CharW-1:0]  char_q;

  logic                 out_free;
  logic                 step;
  logic                 req_valid;
  hcb_pkg::char_class_t char_class;
  hcb_pkg::bus_req_t    req;
  hcb_pkg::bus_req_t    out_req;

  // the held character is applied once the result register can take its request
  assign step       = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // payload capture on each transfer
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      char_q <= char_in_i;
    end
  end

  hcb_char_decode u_decode (
    .char_i  (char_q),
    .class_o (char_class)
  );

  hcb_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .class_i     (char_class),
    .req_valid_o (req_valid),
    .req_o       (req)
  );

  hcb_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step && req_valid),
    .req_i   (req),
    .free_o  (out_free),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .req_o   (out_req)
  );

  assign is_write_o    = out_req.is_write;
  assign bus_address_o = out_req.bus_address;
  assign write_data_o  = out_req.write_data;

endmodule

FILE: rtl/core/hcb_checker.sv
// hcb_checker: port level assertions for the hex command to bus request unit
// depends on hcb_pkg; bound to hex_command_to_bus_request_unit
`timescale 1ns / 1ps

module hcb_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic                        is_write_o,
  input logic [hcb_pkg::WordW-1:0]   bus_address_o,
  input logic [hcb_pkg::WordW-1:0]   write_data_o
);

  // a stalled request holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(is_write_o) && $stable(bus_address_o) && $stable(write_data_o))
    else $error("stalled request changed");

  // read requests carry zero data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_write_o |-> write_data_o == '0)
    else $error("read request with nonzero data");

  // input only stalls behind a full, untaken result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // a fresh request follows an input transfer, held in the input register and then in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("request without a preceding character");

endmodule

bind hex_command_to_bus_request_unit hcb_checker u_hcb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .is_write_o    (is_write_o),
  .bus_address_o (bus_address_o),
  .write_data_o  (write_data_o)
);

FILE: verif/hcb_request_checker.sv
// hcb_request_checker: watches both channels of the hex command unit, predicts requests, compares
// depends on hcb_pkg for character codes, digit count and the bus request type
`timescale 1ns / 1ps

module hcb_request_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [hcb_pkg::CharW-1:0]   char_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic                        is_write_i,
  input  logic [hcb_pkg::WordW-1:0]   bus_address_i,
  input  logic [hcb_pkg::WordW-1:0]   write_data_i,
  output int                          fail_count_o,
  output int                          pending_o
);
  import hcb_pkg::*;

  // parser state as the block should hold it
  logic            mode_read;
  logic [CntW-1:0] addr_digits;
  logic [CntW-1:0] data_digits;
  logic [WordW-1:0] addr_acc;
  logic [WordW-1:0] data_acc;

  bus_req_t pending_requests[$];

  task automatic clear_command();
    addr_digits = '0;
    data_digits = '0;
    addr_acc    = '0;
    data_acc    = '0;
  endtask

  // one accepted character through the parser
  task automatic parse_char(input logic [CharW-1:0] c);
    logic            is_hex;
    logic [NibW-1:0] nib;
    bus_req_t        req;
    is_hex = 1'b1;
    nib    = '0;
    if (c >= ChZero && c <= ChNine) begin
      nib = NibW'(c - ChZero);
    end else if (c >= ChUpA && c <= ChUpF) begin
      nib = NibW'(c - ChUpA) + NibTen;
    end else begin
      is_hex = 1'b0;
    end

    if (addr_digits < DigitsLast) begin
      if (c == ChUpR || c == ChLowR) begin
        mode_read = 1'b1;
      end else if (c == ChUpW || c == ChLowW) begin
        mode_read = 1'b0;
      end
      if (is_hex) begin
        addr_acc    = {addr_acc[WordW-NibW-1:0], nib};
        addr_digits = addr_digits + 1'b1;
        if (addr_digits == DigitsLast && mode_read) begin
          req.is_write    = 1'b0;
          req.bus_address = addr_acc;
          req.write_data  = '0;
          pending_requests.push_back(req);
          clear_command();
        end
      end
    end else if (is_hex) begin
      // data phase, mode letters have no effect here
      data_acc    = {data_acc[WordW-NibW-1:0], nib};
      data_digits = data_digits + 1'b1;
      if (data_digits == DigitsLast) begin
        req.is_write    = 1'b1;
        req.bus_address = addr_acc;
        req.write_data  = data_acc;
        pending_requests.push_back(req);
        clear_command();
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bus_req_t want;
    if (!rst_ni) begin
      mode_read = 1'b1;
      clear_command();
      pending_requests.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_requests.size() == 0) begin
          $error("request with none expected: is_write %0d bus_address %08h write_data %08h",
                 is_write_i, bus_address_i, write_data_i);
          fail_count_o++;
        end else begin
          want = pending_requests.pop_front();
          if (is_write_i !== want.is_write) begin
            $error("is_write: expected %0d, actual %0d", want.is_write, is_write_i);
            fail_count_o++;
          end
          if (bus_address_i !== want.bus_address) begin
            $error("bus_address: expected %08h, actual %08h", want.bus_address, bus_address_i);
            fail_count_o++;
          end
          if (write_data_i !== want.write_data) begin
            $error("write_data: expected %08h, actual %08h", want.write_data, write_data_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        parse_char(char_i);
      end
      pending_o = pending_requests.size();
    end
  end

endmodule

FILE: verif/testbench.sv
// testbench: drives character streams into hex_command_to_bus_request_unit and gives the verdict
// depends on hcb_pkg, the unit's rtl and hcb_request_checker
`timescale 1ns / 1ps

module testbench;
  import hcb_pkg::*;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [CharW-1:0] char_in_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic             is_write_o;
  logic [WordW-1:0] bus_address_o;
  logic [WordW-1:0] write_data_o;

  int fail_count;
  int pending;

  // no idling on either side while set
  logic quiet;
  // characters sent that the parser acts on (digits and mode letters)
  int   useful_sent;
  // our guess of the mode, steers command shapes only
  logic want_write;

  // opening sequence: extreme bytes and neighbors of the digit ranges are ignored,
  // a mode switch to write in the middle of the address, mode letters during data
  logic [CharW-1:0] opening[] = '{
    8'h00, 8'hFF, ChUpR, ChZero, ChNine,
    8'h2F, 8'h3A,                          // just below '0' and just above '9'
    ChUpA, ChUpF,
    8'h40, 8'h47,                          // just below 'A' and just above 'F'
    8'h61, 8'h66,                          // lowercase 'a' and 'f' are no digits
    ChLowW, ChZero, ChZero, ChUpF, ChUpF,  // address complete, write mode
    ChLowR, ChUpW,                         // ignored while data is collected
    ChUpF, ChUpF, ChUpF, ChUpF, ChZero, ChZero, ChZero, ChNine
  };

  hex_command_to_bus_request_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .char_in_i     (char_in_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .is_write_o    (is_write_o),
    .bus_address_o (bus_address_o),
    .write_data_o  (write_data_o)
  );

  hcb_request_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .char_i        (char_in_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .is_write_i    (is_write_o),
    .bus_address_i (bus_address_o),
    .write_data_i  (write_data_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // result side stalls at random, about 18 percent of the time, outside the quiet stretch
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= quiet || ($urandom_range(99) >= 18);
    end
  end

  // one character transfer, with random idle cycles ahead of it
  task automatic send_char(input logic [CharW-1:0] c);
    while (!quiet && $urandom_range(99) < 18) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    char_in_i  <= c;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if ((c >= ChZero && c <= ChNine) || (c >= ChUpA && c <= ChUpF) ||
        c == ChUpR || c == ChLowR || c == ChUpW || c == ChLowW) begin
      useful_sent++;
    end
  endtask

  function automatic logic [CharW-1:0] hex_char(input logic [NibW-1:0] n);
    return (n < NibTen) ? ChZero + CharW'(n) : ChUpA + CharW'(n - NibTen);
  endfunction

  // random noise byte now and then: anything at all, or a lowercase hex letter
  task automatic maybe_noise();
    if ($urandom_range(99) < 8) begin
      if ($urandom_range(3) == 0) begin
        send_char(8'h61 + CharW'($urandom_range(5)));
      end else begin
        send_char(CharW'($urandom_range(255)));
      end
    end
  endtask

  // eight digits, sometimes all zero or all F to hit the word extremes
  task automatic send_word();
    int unsigned shape;
    shape = $urandom_range(7);
    for (int i = 0; i < HexDigits; i++) begin
      maybe_noise();
      case (shape)
        0: send_char(ChZero);
        1: send_char(ChUpF);
        default: send_char(hex_char(NibW'($urandom_range(15))));
      endcase
    end
  endtask

  // mostly well formed commands: optional mode letter, address, and data in write mode
  task automatic send_command();
    if ($urandom_range(9) < 7) begin
      case ($urandom_range(3))
        0: begin send_char(ChUpR); want_write = 1'b0; end
        1: begin send_char(ChLowR); want_write = 1'b0; end
        2: begin send_char(ChUpW); want_write = 1'b1; end
        default: begin send_char(ChLowW); want_write = 1'b1; end
      endcase
    end
    send_word();
    if (want_write) begin
      // mode letters dropped into the data phase must change nothing
      if ($urandom_range(3) == 0) begin
        send_char($urandom_range(1) ? ChUpR : ChLowR);
      end
      send_word();
    end
  endtask

  initial begin
    in_valid_i  <= 1'b0;
    char_in_i   <= '0;
    rst_ni      <= 1'b0;
    quiet       <= 1'b0;
    useful_sent = 0;
    want_write  = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening[i]) begin
      send_char(opening[i]);
    end
    want_write = 1'b1;

    while (useful_sent < 1000) begin
      quiet <= (useful_sent >= 400 && useful_sent < 600);
      send_command();
    end
    in_valid_i <= 1'b0;
    quiet      <= 1'b0;

    // drain, then keep the clock running to catch stray requests
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("hex_command_to_bus_request_unit regression: pass");
    end else begin
      $display("hex_command_to_bus_request_unit regression: fail");
    end
    $finish;
  end

  // a run that hangs is ended here with a fail verdict
  initial begin
    #2000000;
    $display("hex_command_to_bus_request_unit regression: fail");
    $finish;
  end

endmodule
